// ===== sv/jgcl_pkg.sv =====
// shared types, constants and helpers of the joystick gesture code lock
// no dependencies; imported by every other file of the block

package jgcl_pkg;

  localparam int SAMPLE_W     = 10;
  localparam int CODE_LEN_DEF = 4;
  localparam int APB_ADDR_W   = 4;
  localparam int APB_DATA_W   = 32;

  localparam logic [SAMPLE_W-1:0] CENTER_RST = SAMPLE_W'(512);
  localparam logic [SAMPLE_W-1:0] LIMIT_RST  = SAMPLE_W'(200);

  typedef logic [SAMPLE_W-1:0] sample_t;

  // instantaneous stick direction
  typedef enum logic [2:0] {
    STICK_CENTER = 3'd0,
    STICK_UP     = 3'd1,
    STICK_DOWN   = 3'd2,
    STICK_LEFT   = 3'd3,
    STICK_RIGHT  = 3'd4
  } dir_t;

  // confirmed gesture code
  typedef enum logic [1:0] {
    GEST_UP    = 2'd0,
    GEST_DOWN  = 2'd1,
    GEST_LEFT  = 2'd2,
    GEST_RIGHT = 2'd3
  } gest_t;

  typedef enum logic [1:0] {
    VERDICT_PENDING = 2'd0,
    VERDICT_OK      = 2'd1,
    VERDICT_REJECT  = 2'd2
  } verdict_t;

  // register index, from paddr[3:2]
  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_LIMIT    = 2'd2,
    REG_ENROLL   = 2'd3
  } reg_idx_t;

  // calibration seen by the classifier
  typedef struct packed {
    sample_t center_x;
    sample_t center_y;
    sample_t deflect_limit;
  } front_cfg_t;

  // mode control seen by the sequencer
  typedef struct packed {
    logic enroll_mode;
    logic restart;
  } back_ctl_t;

  // head of the direction queue
  typedef struct packed {
    logic valid;
    dir_t dir;
  } q_head_t;

  function automatic gest_t to_gesture(dir_t d);
    gest_t g;
    case (d)
      STICK_UP:    g = GEST_UP;
      STICK_DOWN:  g = GEST_DOWN;
      STICK_LEFT:  g = GEST_LEFT;
      STICK_RIGHT: g = GEST_RIGHT;
      default:     g = GEST_UP;
    endcase
    return g;
  endfunction

endpackage

// ===== sv/jgcl_if.sv =====
// valid/ready channel interfaces for joystick samples and lock results
// depends on jgcl_pkg

interface jgcl_in_if;
  logic               valid;
  logic               ready;
  jgcl_pkg::sample_t  sample_x;
  jgcl_pkg::sample_t  sample_y;

  modport source (output valid, output sample_x, output sample_y, input ready);
  modport sink   (input valid, input sample_x, input sample_y, output ready);
endinterface

interface jgcl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  direction_now;
  logic        gesture_valid;
  logic [1:0]  gesture_dir;
  logic [2:0]  step_reached;
  logic        session_done;
  logic [1:0]  verdict;

  modport source (output valid, output direction_now, output gesture_valid,
                  output gesture_dir, output step_reached, output session_done,
                  output verdict, input ready);
  modport sink   (input valid, input direction_now, input gesture_valid,
                  input gesture_dir, input step_reached, input session_done,
                  input verdict, output ready);
endinterface

// ===== sv/joystick_gesture_code_lock.sv =====
// top level of the joystick gesture code lock: apb registers, front, queue, back
// depends on jgcl_pkg, jgcl_if, jgcl_front, jgcl_fifo, jgcl_back

// Joystick gesture code lock. Each sample word (sample_x, sample_y) gives
// exactly one result word. Throughput is one sample per clock while the result
// side is not stalled: the front end classifies the sample combinationally as
// it is taken into a two-entry queue, and the back end pops one entry per cycle
// into the result register whenever that register is empty or being read.
// A sample passes the queue, then the result register; the queue and the result
// register let the input keep flowing for two more samples while the result
// side is stalled. Registers (APB, byte address 4*index): center_x (0),
// center_y (1), deflect_limit (2), enroll_mode (3); any write to enroll_mode
// restarts the session. Registers should only be written while the block is
// idle. The code store is held in flip-flops and cleared by reset, so no
// initialization sweep is needed after reset.

module joystick_gesture_code_lock #(
  parameter int CODE_LEN = jgcl_pkg::CODE_LEN_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  jgcl_in_if.sink                              smp,
  jgcl_out_if.source                           res,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [jgcl_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [jgcl_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [jgcl_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import jgcl_pkg::*;

  // configuration registers
  sample_t    center_x;
  sample_t    center_y;
  sample_t    deflect_limit;
  logic       enroll_mode;
  logic       restart;

  logic       wr_en;
  reg_idx_t   wr_idx;

  front_cfg_t fcfg;
  back_ctl_t  bctl;

  // queue hookup
  logic       push;
  dir_t       push_dir;
  logic       pop;
  logic       q_full;
  q_head_t    head;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= CENTER_RST;
      center_y      <= CENTER_RST;
      deflect_limit <= LIMIT_RST;
      enroll_mode   <= 1'b0;
      restart       <= 1'b0;
    end else begin
      // one-cycle pulse after every mode write
      restart <= wr_en && (wr_idx == REG_ENROLL);
      if (wr_en) begin
        case (wr_idx)
          REG_CENTER_X: center_x      <= pwdata[SAMPLE_W-1:0];
          REG_CENTER_Y: center_y      <= pwdata[SAMPLE_W-1:0];
          REG_LIMIT:    deflect_limit <= pwdata[SAMPLE_W-1:0];
          REG_ENROLL:   enroll_mode   <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  // register read-back
  always_comb begin
    case (wr_idx)
      REG_CENTER_X: prdata = APB_DATA_W'(center_x);
      REG_CENTER_Y: prdata = APB_DATA_W'(center_y);
      REG_LIMIT:    prdata = APB_DATA_W'(deflect_limit);
      REG_ENROLL:   prdata = APB_DATA_W'(enroll_mode);
      default:      prdata = '0;
    endcase
  end

  assign fcfg.center_x      = center_x;
  assign fcfg.center_y      = center_y;
  assign fcfg.deflect_limit = deflect_limit;
  assign bctl.enroll_mode   = enroll_mode;
  assign bctl.restart       = restart;

  // sample classification into the queue
  jgcl_front u_front (
    .smp      (smp),
    .cfg      (fcfg),
    .q_full   (q_full),
    .push     (push),
    .push_dir (push_dir)
  );

  // short direction queue, lets front and back stall independently
  jgcl_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_dir (push_dir),
    .pop      (pop),
    .full     (q_full),
    .head     (head)
  );

  // gesture sequencing and result register
  jgcl_back #(
    .CODE_LEN (CODE_LEN)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .ctl  (bctl),
    .head (head),
    .pop  (pop),
    .res  (res)
  );

  // a verdict is only given when the session ends
  a_verdict_done: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.session_done |-> res.verdict == VERDICT_PENDING)
    else $error("verdict without session end");

  // a session only ends on a confirmed gesture
  a_done_gesture: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.session_done |-> res.gesture_valid)
    else $error("session end without gesture");

  // gesture code is zero when nothing is confirmed
  a_gdir_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.gesture_valid |-> res.gesture_dir == GEST_UP)
    else $error("gesture code without gesture");

  // a gesture is confirmed only by a return to center
  a_confirm_center: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.gesture_valid |-> res.direction_now == STICK_CENTER)
    else $error("gesture confirmed off center");

endmodule

// ===== sv/jgcl_front.sv =====
// front end: accepts samples, removes calibration offset, classifies direction
// depends on jgcl_pkg and jgcl_in_if

module jgcl_front (
  jgcl_in_if.sink                 smp,
  input  jgcl_pkg::front_cfg_t    cfg,
  input  logic                    q_full,
  output logic                    push,
  output jgcl_pkg::dir_t          push_dir
);
  import jgcl_pkg::*;

  logic [SAMPLE_W:0] sx, sy, cx, cy, lim;
  logic left, right, down, up;

  assign sx  = {1'b0, smp.sample_x};
  assign sy  = {1'b0, smp.sample_y};
  assign cx  = {1'b0, cfg.center_x};
  assign cy  = {1'b0, cfg.center_y};
  assign lim = {1'b0, cfg.deflect_limit};

  // x - cx < -lim  <=>  x + lim < cx, all unsigned
  assign left  = (sx + lim) < cx;
  assign right = sx > (cx + lim);
  assign down  = (sy + lim) < cy;
  assign up    = sy > (cy + lim);

  always_comb begin
    if (left) begin
      push_dir = STICK_LEFT;
    end else if (right) begin
      push_dir = STICK_RIGHT;
    end else if (down) begin
      push_dir = STICK_DOWN;
    end else if (up) begin
      push_dir = STICK_UP;
    end else begin
      push_dir = STICK_CENTER;
    end
  end

  assign smp.ready = !q_full;
  assign push      = smp.valid && !q_full;

endmodule

// ===== sv/jgcl_fifo.sv =====
// two-entry queue of classified directions between front and back
// depends on jgcl_pkg

module jgcl_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  jgcl_pkg::dir_t       push_dir,
  input  logic                 pop,
  output logic                 full,
  output jgcl_pkg::q_head_t    head
);
  import jgcl_pkg::*;

  dir_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = count == 2'd2;
  assign head.valid = count != 2'd0;
  assign head.dir   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_dir;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/jgcl_back.sv =====
// back end: gesture tracking, code store, enroll/verify sequencing, result register
// depends on jgcl_pkg and jgcl_out_if

module jgcl_back #(
  parameter int CODE_LEN = jgcl_pkg::CODE_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  jgcl_pkg::back_ctl_t  ctl,
  input  jgcl_pkg::q_head_t    head,
  output logic                 pop,
  jgcl_out_if.source           res
);
  import jgcl_pkg::*;

  localparam int IDX_W = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
  localparam int CNT_W = $clog2(CODE_LEN + 1);
  localparam int RX_W  = (CNT_W > 3) ? CNT_W : 3;

  gest_t            code_store [CODE_LEN];
  logic [IDX_W-1:0] step_count, step_next;
  dir_t             pending, pending_next;

  logic             res_valid;
  dir_t             res_dir;
  logic             res_gvalid;
  gest_t            res_gdir;
  logic [2:0]       res_step;
  logic             res_done;
  verdict_t         res_verdict;

  logic             gv_next;
  gest_t            gd_next;
  logic [RX_W-1:0]  reached_next;
  logic             done_next;
  verdict_t         verdict_next;
  logic             store_we;
  gest_t            gcur;
  logic             last;
  logic [CNT_W-1:0] step_inc;

  assign pop = head.valid && (!res_valid || res.ready);

  always_comb begin
    gcur         = to_gesture(pending);
    last         = step_count == IDX_W'(CODE_LEN - 1);
    step_inc     = CNT_W'(step_count) + CNT_W'(1);
    pending_next = pending;
    step_next    = step_count;
    store_we     = 1'b0;
    gv_next      = 1'b0;
    gd_next      = GEST_UP;
    done_next    = 1'b0;
    verdict_next = VERDICT_PENDING;
    reached_next = RX_W'(step_count);
    if (pending == STICK_CENTER) begin
      if (head.dir != STICK_CENTER) begin
        pending_next = head.dir;
      end
    end else if (head.dir == STICK_CENTER) begin
      gv_next      = 1'b1;
      gd_next      = gcur;
      pending_next = STICK_CENTER;
      if (ctl.enroll_mode || code_store[step_count] == gcur) begin
        store_we     = ctl.enroll_mode;
        reached_next = RX_W'(step_inc);
        if (last) begin
          done_next    = 1'b1;
          verdict_next = VERDICT_OK;
          step_next    = '0;
        end else begin
          step_next    = step_count + IDX_W'(1);
        end
      end else begin
        done_next    = 1'b1;
        verdict_next = VERDICT_REJECT;
        step_next    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CODE_LEN; i++) begin
        code_store[i] <= GEST_UP;
      end
    end else if (pop && store_we) begin
      code_store[step_count] <= gd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_dir     <= head.dir;
      res_gvalid  <= gv_next;
      res_gdir    <= gd_next;
      res_step    <= reached_next[2:0];
      res_done    <= done_next;
      res_verdict <= verdict_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      step_count <= '0;
      pending    <= STICK_CENTER;
    end else begin
      if (pop) begin
        res_valid  <= 1'b1;
      end else if (res.ready) begin
        res_valid  <= 1'b0;
      end
      // mode change restarts the session
      if (ctl.restart) begin
        step_count <= '0;
        pending    <= STICK_CENTER;
      end else if (pop) begin
        step_count <= step_next;
        pending    <= pending_next;
      end
    end
  end

  assign res.valid         = res_valid;
  assign res.direction_now = res_dir;
  assign res.gesture_valid = res_gvalid;
  assign res.gesture_dir   = res_gdir;
  assign res.step_reached  = res_step;
  assign res.session_done  = res_done;
  assign res.verdict       = res_verdict;

endmodule
